// ----- rtl/core/lbfg_pkg.sv -----
package lbfg_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned FREQ_W = 32;
    localparam int unsigned PCT_W  = 8;
    localparam int unsigned STAT_W = 2;

    // shared divider: dividend shift register and step counts
    localparam int unsigned DIVD_W     = 96;
    localparam int unsigned DIV1_STEPS = 89;   // busy*freq < 2^89
    localparam int unsigned DIV2_STEPS = 39;   // q*100 < 2^39
    localparam int unsigned DIV1_ALIGN = DIVD_W - DIV1_STEPS;
    localparam int unsigned DIV2_ALIGN = DIVD_W - DIV2_STEPS;
    localparam int unsigned CNT_W      = $clog2(DIV1_STEPS);

    localparam logic [PCT_W-1:0] DEF_UP   = 8'd90;
    localparam logic [PCT_W-1:0] DEF_DOWN = 8'd5;
    localparam logic [PCT_W-1:0] PERCENT  = 8'd100;
    localparam int unsigned BIG_BIT   = 24;
    localparam int unsigned BIG_SHIFT = 7;

    localparam logic CFG_UP   = 1'b0;
    localparam logic CFG_DOWN = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADCFG   = 2'd1,
        ST_TIMEBACK = 2'd2,
        ST_REBASED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REBASE,
        OP_BAD,
        OP_BACK,
        OP_BASE,
        OP_CLAMP,
        OP_SCALE,
        OP_PROD,
        OP_MAX,
        OP_KEEP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV,
        OP_PCT,
        OP_QUOT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic bad;
        logic back;
        logic elap_zero;
        logic go_max;
        logic go_keep;
    } t_stat;

    typedef struct packed {
        logic             we;
        logic             index;
        logic [PCT_W-1:0] data;
    } t_cfg;

    // v * 100 as shifts and adds, modulo 2^64
    function automatic logic [DATA_W-1:0] times_pct(input logic [DATA_W-1:0] v);
        return (v << 6) + (v << 5) + (v << 2);
    endfunction

endpackage

// ----- rtl/core/load_based_frequency_governor.sv -----
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_kind, i_busy_total_us, i_now_us, i_current_freq
// out       output     o_out_valid / i_out_stall o_status, o_target_freq, o_at_max
// cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One beat at a time; the paths from acceptance to the output register load are:
// rebase, bad thresholds and time back; zero elapsed time; max/keep; and a scaled target,
// which runs the shared 1-bit-a-cycle divider (89 steps for busy*freq/elapsed, 39 for
// the percent scaling). The next beat can be taken in the cycle after the output register load.
// Synchronous active-low reset clears the controller and baselines, thresholds go to 90/5.
// A result waiting under out stall does not block acceptance of the next beat.
module load_based_frequency_governor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [lbfg_pkg::DATA_W-1:0]    i_busy_total_us,
    input  logic [lbfg_pkg::DATA_W-1:0]    i_now_us,
    input  logic [lbfg_pkg::FREQ_W-1:0]    i_current_freq,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lbfg_pkg::STAT_W-1:0]    o_status,
    output logic [lbfg_pkg::FREQ_W-1:0]    o_target_freq,
    output logic                           o_at_max,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [lbfg_pkg::PCT_W-1:0]     i_cfg_data
);

    lbfg_pkg::t_cmd  w_cmd;
    lbfg_pkg::t_stat w_stat;
    lbfg_pkg::t_cfg  w_cfg;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    lbfg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    lbfg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .i_kind          (i_kind),
        .i_busy_total_us (i_busy_total_us),
        .i_now_us        (i_now_us),
        .i_current_freq  (i_current_freq),
        .o_stat          (w_stat),
        .o_status        (o_status),
        .o_target_freq   (o_target_freq),
        .o_at_max        (o_at_max)
    );

    // error results carry no target
    a_err_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != lbfg_pkg::ST_OK) |-> (o_target_freq == '0) && !o_at_max)
        else $error("error status with non-zero target");

    // maximum request always shows as all ones
    a_max_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_at_max |-> (o_target_freq == '1) && (o_status == lbfg_pkg::ST_OK))
        else $error("at_max without all-ones target");

    // an accepted beat keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a beat is in flight");

    // the output register is only reloaded as the controller hands over
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !o_out_valid || !i_out_stall)
        else $error("output overwritten under stall");

endmodule

// ----- rtl/core/lbfg_div.sv -----
module lbfg_div (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_step,
    input  logic [lbfg_pkg::DIVD_W-1:0]       i_dividend,
    input  logic [lbfg_pkg::DATA_W-1:0]       i_divisor,
    output logic [lbfg_pkg::DATA_W-1:0]       o_quot
);

    logic [lbfg_pkg::DIVD_W-1:0] r_work;
    logic [lbfg_pkg::DATA_W-1:0] r_rem;
    logic [lbfg_pkg::DATA_W-1:0] r_divisor;
    logic [lbfg_pkg::DATA_W:0]   w_trial;
    logic [lbfg_pkg::DATA_W:0]   w_diff;
    logic                        w_ge;

    // restoring division, one quotient bit a cycle; quotient bits enter at the bottom
    assign w_trial = {r_rem, r_work[lbfg_pkg::DIVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_divisor};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign o_quot  = r_work[lbfg_pkg::DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (i_step) begin
            r_work <= {r_work[lbfg_pkg::DIVD_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[lbfg_pkg::DATA_W-1:0] : w_trial[lbfg_pkg::DATA_W-1:0];
        end
    end

endmodule

// ----- rtl/core/lbfg_dp.sv -----
module lbfg_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lbfg_pkg::t_cfg                   i_cfg,
    input  lbfg_pkg::t_cmd                   i_cmd,
    input  logic                             i_kind,
    input  logic [lbfg_pkg::DATA_W-1:0]      i_busy_total_us,
    input  logic [lbfg_pkg::DATA_W-1:0]      i_now_us,
    input  logic [lbfg_pkg::FREQ_W-1:0]      i_current_freq,
    output lbfg_pkg::t_stat                  o_stat,
    output logic [lbfg_pkg::STAT_W-1:0]      o_status,
    output logic [lbfg_pkg::FREQ_W-1:0]      o_target_freq,
    output logic                             o_at_max
);

    localparam int unsigned DW = lbfg_pkg::DATA_W;
    localparam int unsigned FW = lbfg_pkg::FREQ_W;
    localparam int unsigned PW = lbfg_pkg::PCT_W;

    logic [PW-1:0] r_up, r_down;
    logic [DW-1:0] r_base, r_last;
    logic          r_kind;
    logic [DW-1:0] r_cnt, r_now;
    logic [FW-1:0] r_freq;
    logic [DW-1:0] r_busy, r_elap;
    logic [DW-1:0] r_pb, r_pe, r_pd;
    logic [DW-1:0] r_acc;
    logic [lbfg_pkg::STAT_W-1:0] r_res_status, r_out_status;
    logic [FW-1:0] r_res_target, r_out_target;
    logic          r_res_max, r_out_max;

    logic [PW-1:0] w_up, w_down, w_band, w_scale_div;
    logic [DW-1:0] w_busy_raw, w_elapsed, w_hi, w_quot, w_q100;
    logic [lbfg_pkg::DIVD_W-1:0] w_prod, w_dividend;
    logic [DW-1:0] w_divisor;
    logic          w_div_load, w_big;

    assign w_up        = (r_up == '0) ? lbfg_pkg::DEF_UP : r_up;
    assign w_down      = (r_down == '0) ? lbfg_pkg::DEF_DOWN : r_down;
    assign w_band      = w_up - w_down;
    assign w_scale_div = w_up - (w_down >> 1);

    assign w_busy_raw = (r_cnt < r_base) ? '0 : r_cnt - r_base;
    assign w_elapsed  = r_now - r_last;
    assign w_big      = (r_busy[DW-1:lbfg_pkg::BIG_BIT] != '0)
                     || (r_elap[DW-1:lbfg_pkg::BIG_BIT] != '0);

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.bad       = (w_up > lbfg_pkg::PERCENT) || (w_up < w_down);
        o_stat.back      = r_now < r_last;
        o_stat.elap_zero = r_elap == '0;
        o_stat.go_max    = (r_pb > r_pe) || (r_freq == '0);
        o_stat.go_keep   = r_pb > r_pd;
    end

    // upper half of busy times freq, added to the lower half from the previous cycle
    assign w_hi   = r_busy[DW-1:FW] * r_freq;
    assign w_prod = {{FW{1'b0}}, r_acc} + {w_hi, {FW{1'b0}}};
    assign w_q100 = lbfg_pkg::times_pct(w_quot);

    assign w_div_load = (i_cmd.op == lbfg_pkg::OP_MUL_HI) || (i_cmd.op == lbfg_pkg::OP_PCT);

    always_comb begin
        if (i_cmd.op == lbfg_pkg::OP_PCT) begin
            w_dividend = {w_q100[lbfg_pkg::DIV2_STEPS-1:0], {lbfg_pkg::DIV2_ALIGN{1'b0}}};
            w_divisor  = {{(DW-PW){1'b0}}, w_scale_div};
        end else begin
            w_dividend = {w_prod[lbfg_pkg::DIVD_W-lbfg_pkg::DIV1_ALIGN-1:0],
                          {lbfg_pkg::DIV1_ALIGN{1'b0}}};
            w_divisor  = r_elap;
        end
    end

    lbfg_div u_div (
        .i_clk      (i_clk),
        .i_load     (w_div_load),
        .i_step     (i_cmd.op == lbfg_pkg::OP_DIV),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up   <= lbfg_pkg::DEF_UP;
            r_down <= lbfg_pkg::DEF_DOWN;
        end else if (i_cfg.we) begin
            if (i_cfg.index == lbfg_pkg::CFG_UP) begin
                r_up <= i_cfg.data;
            end else begin
                r_down <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_last <= '0;
        end else begin
            unique case (i_cmd.op)
                lbfg_pkg::OP_REBASE, lbfg_pkg::OP_BASE: begin
                    r_base <= r_cnt;
                    r_last <= r_now;
                end
                lbfg_pkg::OP_BACK: begin
                    r_base <= r_cnt;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            lbfg_pkg::OP_LOAD: begin
                r_kind <= i_kind;
                r_cnt  <= i_busy_total_us;
                r_now  <= i_now_us;
                r_freq <= i_current_freq;
            end
            lbfg_pkg::OP_REBASE: begin
                r_res_status <= lbfg_pkg::ST_REBASED;
                r_res_target <= '0;
                r_res_max    <= 1'b0;
            end
            lbfg_pkg::OP_BAD: begin
                r_res_status <= lbfg_pkg::ST_BADCFG;
                r_res_target <= '0;
                r_res_max    <= 1'b0;
            end
            lbfg_pkg::OP_BACK: begin
                r_res_status <= lbfg_pkg::ST_TIMEBACK;
                r_res_target <= '0;
                r_res_max    <= 1'b0;
            end
            lbfg_pkg::OP_BASE: begin
                r_busy <= w_busy_raw;
                r_elap <= w_elapsed;
            end
            lbfg_pkg::OP_CLAMP: begin
                if (r_busy > r_elap) begin
                    r_busy <= r_elap;
                end
            end
            lbfg_pkg::OP_SCALE: begin
                if (w_big) begin
                    r_busy <= r_busy >> lbfg_pkg::BIG_SHIFT;
                    r_elap <= r_elap >> lbfg_pkg::BIG_SHIFT;
                end
            end
            lbfg_pkg::OP_PROD: begin
                r_pb <= lbfg_pkg::times_pct(r_busy);
                r_pe <= r_elap * w_up;
                r_pd <= r_elap * w_band;
            end
            lbfg_pkg::OP_MAX: begin
                r_res_status <= lbfg_pkg::ST_OK;
                r_res_target <= '1;
                r_res_max    <= 1'b1;
            end
            lbfg_pkg::OP_KEEP: begin
                r_res_status <= lbfg_pkg::ST_OK;
                r_res_target <= r_freq;
                r_res_max    <= 1'b0;
            end
            lbfg_pkg::OP_MUL_LO: begin
                r_acc <= r_busy[FW-1:0] * r_freq;
            end
            lbfg_pkg::OP_QUOT: begin
                r_res_status <= lbfg_pkg::ST_OK;
                if (w_quot[DW-1:FW] != '0) begin
                    r_res_target <= '1;
                    r_res_max    <= 1'b1;
                end else begin
                    r_res_target <= w_quot[FW-1:0];
                    r_res_max    <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_target <= r_res_target;
            r_out_max    <= r_res_max;
        end
    end

    assign o_status      = r_out_status;
    assign o_target_freq = r_out_target;
    assign o_at_max      = r_out_max;

endmodule

// ----- rtl/core/lbfg_ctrl.sv -----
module lbfg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_stall,
    input  lbfg_pkg::t_stat i_stat,
    output lbfg_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLAMP,
        S_SCALE,
        S_PROD,
        S_DECIDE,
        S_MUL_HI,
        S_DIV1,
        S_PCT,
        S_DIV2,
        S_QUOT,
        S_DONE
    } t_state;

    localparam logic [lbfg_pkg::CNT_W-1:0] DIV1_LAST = lbfg_pkg::CNT_W'(lbfg_pkg::DIV1_STEPS - 1);
    localparam logic [lbfg_pkg::CNT_W-1:0] DIV2_LAST = lbfg_pkg::CNT_W'(lbfg_pkg::DIV2_STEPS - 1);

    t_state                     r_state, n_state;
    logic [lbfg_pkg::CNT_W-1:0] r_count, n_count;
    logic                       r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd.op     = lbfg_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = lbfg_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.kind) begin
                    o_cmd.op = lbfg_pkg::OP_REBASE;
                    n_state  = S_DONE;
                end else if (i_stat.bad) begin
                    o_cmd.op = lbfg_pkg::OP_BAD;
                    n_state  = S_DONE;
                end else if (i_stat.back) begin
                    o_cmd.op = lbfg_pkg::OP_BACK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = lbfg_pkg::OP_BASE;
                    n_state  = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.op = lbfg_pkg::OP_CLAMP;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                if (i_stat.elap_zero) begin
                    o_cmd.op = lbfg_pkg::OP_MAX;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = lbfg_pkg::OP_SCALE;
                    n_state  = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.op = lbfg_pkg::OP_PROD;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                priority if (i_stat.go_max) begin
                    o_cmd.op = lbfg_pkg::OP_MAX;
                    n_state  = S_DONE;
                end else if (i_stat.go_keep) begin
                    o_cmd.op = lbfg_pkg::OP_KEEP;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = lbfg_pkg::OP_MUL_LO;
                    n_state  = S_MUL_HI;
                end
            end
            S_MUL_HI: begin
                o_cmd.op = lbfg_pkg::OP_MUL_HI;
                n_count  = DIV1_LAST;
                n_state  = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.op = lbfg_pkg::OP_DIV;
                n_count  = r_count - 1'b1;
                if (r_count == '0) begin
                    n_state = S_PCT;
                end
            end
            S_PCT: begin
                o_cmd.op = lbfg_pkg::OP_PCT;
                n_count  = DIV2_LAST;
                n_state  = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.op = lbfg_pkg::OP_DIV;
                n_count  = r_count - 1'b1;
                if (r_count == '0) begin
                    n_state = S_QUOT;
                end
            end
            S_QUOT: begin
                o_cmd.op = lbfg_pkg::OP_QUOT;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule
